// ----- hdl/frac_pkg.sv -----
package frac_pkg;

    typedef enum logic [1:0] {
        KIND_ADD = 2'd0,
        KIND_SUB = 2'd1,
        KIND_MUL = 2'd2,
        KIND_DIV = 2'd3
    } kind_t;

    localparam logic [31:0] MAG_LIMIT = 32'h7FFF_FFFF;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture operands
        logic prod;       // register the partial products
        logic comb;       // form numerator and denominator
        logic gcd_init;   // start the divisor search
        logic gcd_step;   // one search step: a halving or a subtraction
        logic div_init;   // start the two divisions
        logic div_step;   // one quotient bit for both
        logic finish;     // build the result fields
    } frac_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic zero_den;
        logic zero_num;
        logic gcd_done;
        logic div_done;
    } frac_sts_t;

endpackage

// ----- hdl/frac_if.sv -----
interface frac_in_if #(parameter int OPERAND_WIDTH = 16);
    logic                            valid;
    logic                            ready;
    logic [1:0]                      kind;
    logic signed [OPERAND_WIDTH-1:0] a_num;
    logic signed [OPERAND_WIDTH-1:0] a_den;
    logic signed [OPERAND_WIDTH-1:0] b_num;
    logic signed [OPERAND_WIDTH-1:0] b_den;
    modport source (output valid, kind, a_num, a_den, b_num, b_den, input ready);
    modport sink (input valid, kind, a_num, a_den, b_num, b_den, output ready);
endinterface

interface frac_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] res_num;
    logic signed [31:0] res_den;
    logic               error;
    modport source (output valid, res_num, res_den, error, input ready);
    modport sink (input valid, res_num, res_den, error, output ready);
endinterface

// ----- hdl/fraction_arithmetic_reduce_unit.sv -----
// Channel | Direction | Payload
// in      | sink      | kind, a_num, a_den, b_num, b_den
// out     | source    | res_num, res_den, error
//
// One transaction at a time. After the products, a binary divisor search runs from a
// seeding step, and then the two restoring divisions run side by side. A zero
// numerator or denominator finishes without the search or the divisions.
// Reset clears only the controller; a result waits in the output register while
// out is stalled, and in stays not ready until that result is taken.
module fraction_arithmetic_reduce_unit
    import frac_pkg::*;
#(
    parameter int OPERAND_WIDTH = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    frac_in_if.sink    in,
    frac_out_if.source out
);

    frac_cmd_t cmd;
    frac_sts_t sts;

    // Sequencer: steps the datapath through products, divisor search and division.
    frac_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in.valid),
        .in_ready  (in.ready),
        .out_valid (out.valid),
        .out_ready (out.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // Datapath: magnitude and sign arithmetic with the result register.
    frac_dp #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
        .clk     (clk),
        .kind    (in.kind),
        .a_num   (in.a_num),
        .a_den   (in.a_den),
        .b_num   (in.b_num),
        .b_den   (in.b_den),
        .cmd     (cmd),
        .sts     (sts),
        .res_num (out.res_num),
        .res_den (out.res_den),
        .error   (out.error)
    );

endmodule

// ----- hdl/frac_ctrl.sv -----
module frac_ctrl
    import frac_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output frac_cmd_t cmd,
    input  frac_sts_t sts
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_PROD = 7'b0000010,
        S_COMB = 7'b0000100,
        S_GCD  = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_FIN  = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_PROD;
                end
            end
            S_PROD:
            begin
                cmd.prod = 1'b1;
                state_next = S_COMB;
            end
            S_COMB:
            begin
                cmd.comb = 1'b1;
                state_next = S_GCD;
            end
            S_GCD:
            begin
                if (sts.zero_den || sts.zero_num)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_OUT;
                end
                else if (sts.gcd_done)
                begin
                    cmd.div_init = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    cmd.gcd_step = 1'b1;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (state_reg == S_COMB)
        begin
            cmd.gcd_init = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_fin_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid)
        else $error("finish did not lead to output");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.gcd_step && cmd.div_step))
        else $error("gcd and divide active together");

endmodule

// ----- hdl/frac_dp.sv -----
module frac_dp
    import frac_pkg::*;
#(
    parameter int OPERAND_WIDTH = 16
)
(
    input  logic                            clk,
    input  logic [1:0]                      kind,
    input  logic signed [OPERAND_WIDTH-1:0] a_num,
    input  logic signed [OPERAND_WIDTH-1:0] a_den,
    input  logic signed [OPERAND_WIDTH-1:0] b_num,
    input  logic signed [OPERAND_WIDTH-1:0] b_den,
    input  frac_cmd_t                       cmd,
    output frac_sts_t                       sts,
    output logic signed [31:0]              res_num,
    output logic signed [31:0]              res_den,
    output logic                            error
);

    localparam int W  = OPERAND_WIDTH;
    localparam int PW = 2 * W;
    localparam int MW = PW + 1;
    localparam int CW = $clog2(MW + 1);
    localparam int XW = (MW > 32) ? MW : 32;

    logic [1:0]   kind_reg;
    logic [W-1:0] am_reg, adm_reg, bm_reg, bdm_reg;
    logic         as_reg, ads_reg, bs_reg, bds_reg;
    logic [PW-1:0] p1_reg, p2_reg, pd_reg;
    logic          p1s_reg, p2s_reg, pds_reg;
    logic [MW-1:0] nm_reg, dm_reg;
    logic          ns_reg, ds_reg;
    logic [MW-1:0] gx_reg, gy_reg;
    logic [CW-1:0] k_reg;
    logic [MW-1:0] gd_reg;
    logic [MW-1:0] qn_reg, qd_reg, rn_reg, rd_reg;
    logic [CW-1:0] cnt_reg;
    logic signed [31:0] res_num_reg, res_den_reg;
    logic error_reg;

    function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
        mag_of = v[W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [31:0] to_field(input logic s, input logic [MW-1:0] m);
        logic [XW-1:0] mx;
        logic [31:0] c;
        mx = XW'(m);
        c = (mx > XW'(MAG_LIMIT)) ? MAG_LIMIT : mx[31:0];
        to_field = s ? (~c + 1'b1) : c;
    endfunction

    logic [W-1:0] m1a, m1b, m2a, m2b, mda, mdb;
    logic s1, s2, sd;
    logic [MW-1:0] p1e, p2e;
    logic [MW-1:0] rn_sh, rd_sh;

    always_comb
    begin
        m1a = am_reg;  m1b = bdm_reg; s1 = as_reg ^ bds_reg;
        m2a = bm_reg;  m2b = adm_reg; s2 = bs_reg ^ ads_reg;
        mda = adm_reg; mdb = bdm_reg; sd = ads_reg ^ bds_reg;
        unique case (kind_t'(kind_reg))
            KIND_ADD, KIND_SUB: ;
            KIND_MUL:
            begin
                m1b = bm_reg;  s1 = as_reg ^ bs_reg;
            end
            KIND_DIV:
            begin
                mdb = bm_reg;  sd = ads_reg ^ bs_reg;
            end
            default: ;
        endcase
        p1e = {1'b0, p1_reg};
        p2e = {1'b0, p2_reg};
        rn_sh = {rn_reg[MW-2:0], qn_reg[MW-1]};
        rd_sh = {rd_reg[MW-2:0], qd_reg[MW-1]};
    end

    logic add_like;
    logic s2e;
    assign add_like = (kind_reg == KIND_ADD) || (kind_reg == KIND_SUB);
    assign s2e = (kind_reg == KIND_SUB) ? ~p2s_reg : p2s_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind;
            am_reg <= mag_of(a_num);  as_reg  <= a_num[W-1];
            adm_reg <= mag_of(a_den); ads_reg <= a_den[W-1];
            bm_reg <= mag_of(b_num);  bs_reg  <= b_num[W-1];
            bdm_reg <= mag_of(b_den); bds_reg <= b_den[W-1];
        end
        if (cmd.prod)
        begin
            p1_reg <= m1a * m1b; p1s_reg <= s1;
            p2_reg <= m2a * m2b; p2s_reg <= s2;
            pd_reg <= mda * mdb; pds_reg <= sd;
        end
        if (cmd.comb)
        begin
            dm_reg <= {1'b0, pd_reg};
            ds_reg <= pds_reg;
            if (!add_like)
            begin
                nm_reg <= p1e; ns_reg <= p1s_reg;
            end
            else if (p1s_reg == s2e)
            begin
                nm_reg <= p1e + p2e; ns_reg <= p1s_reg;
            end
            else if (p1e >= p2e)
            begin
                nm_reg <= p1e - p2e; ns_reg <= p1s_reg;
            end
            else
            begin
                nm_reg <= p2e - p1e; ns_reg <= s2e;
            end
        end
        if (cmd.gcd_init)
        begin
            gx_reg <= '0;
            gy_reg <= '0;
            k_reg  <= '0;
        end
        // Binary divisor search: common factors of two are counted in k_reg,
        // odd pairs are reduced by a subtraction followed by a halving.
        if (cmd.gcd_step)
        begin
            if (gx_reg == '0 && gy_reg == '0)
            begin
                gx_reg <= nm_reg;
                gy_reg <= dm_reg;
            end
            else if (!gx_reg[0] && !gy_reg[0])
            begin
                gx_reg <= gx_reg >> 1;
                gy_reg <= gy_reg >> 1;
                k_reg  <= k_reg + 1'b1;
            end
            else if (!gx_reg[0])
            begin
                gx_reg <= gx_reg >> 1;
            end
            else if (!gy_reg[0])
            begin
                gy_reg <= gy_reg >> 1;
            end
            else if (gx_reg > gy_reg)
            begin
                gx_reg <= (gx_reg - gy_reg) >> 1;
            end
            else
            begin
                gy_reg <= (gy_reg - gx_reg) >> 1;
            end
        end
        if (cmd.div_init)
        begin
            gd_reg <= gx_reg << k_reg;
            qn_reg <= nm_reg; qd_reg <= dm_reg;
            rn_reg <= '0;     rd_reg <= '0;
            cnt_reg <= CW'(MW);
        end
        if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (rn_sh >= gd_reg)
            begin
                rn_reg <= rn_sh - gd_reg;
                qn_reg <= {qn_reg[MW-2:0], 1'b1};
            end
            else
            begin
                rn_reg <= rn_sh;
                qn_reg <= {qn_reg[MW-2:0], 1'b0};
            end
            if (rd_sh >= gd_reg)
            begin
                rd_reg <= rd_sh - gd_reg;
                qd_reg <= {qd_reg[MW-2:0], 1'b1};
            end
            else
            begin
                rd_reg <= rd_sh;
                qd_reg <= {qd_reg[MW-2:0], 1'b0};
            end
        end
        if (cmd.finish)
        begin
            if (dm_reg == '0)
            begin
                res_num_reg <= '0; res_den_reg <= '0; error_reg <= 1'b1;
            end
            else if (nm_reg == '0)
            begin
                res_num_reg <= '0; res_den_reg <= 32'sd1; error_reg <= 1'b0;
            end
            else
            begin
                res_num_reg <= to_field(ns_reg, qn_reg);
                res_den_reg <= to_field(ds_reg, qd_reg);
                error_reg <= 1'b0;
            end
        end
    end

    // The divisor search is seeded in its first step; it ends when both sides meet.
    assign sts.zero_den = (dm_reg == '0);
    assign sts.zero_num = (nm_reg == '0);
    assign sts.gcd_done = (gx_reg != '0) && (gx_reg == gy_reg);
    assign sts.div_done = (cnt_reg == '0);

    assign res_num = res_num_reg;
    assign res_den = res_den_reg;
    assign error   = error_reg;

    a_gcd_nz: assert property (@(posedge clk)
        cmd.div_init |-> gx_reg != '0)
        else $error("divide started with zero divisor");
    a_div_cnt: assert property (@(posedge clk)
        cmd.div_step |-> cnt_reg != '0)
        else $error("divide stepped past its last bit");
    a_gcd_order: assert property (@(posedge clk)
        cmd.gcd_step |-> !cmd.finish)
        else $error("finish during divisor search");

endmodule

// ----- verif/fraction_arithmetic_reduce_checker.sv -----
module fraction_arithmetic_reduce_checker
    import frac_pkg::*;
#(
    parameter int OPERAND_WIDTH = 16
)
(
    input  logic clk,
    input  logic rst_n,
    frac_in_if   in_ch,
    frac_out_if  out_ch,
    output int   errors,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [31:0] num;
        logic signed [31:0] den;
        logic               err;
    } fraction_t;

    fraction_t reduced_q[$];

    function automatic logic signed [31:0] clamp_to_field(longint value);
        if (value > longint'(MAG_LIMIT)) return MAG_LIMIT;
        if (value < -longint'(MAG_LIMIT)) return -MAG_LIMIT;
        return value[31:0];
    endfunction

    // Exact cross products, then division by the gcd of the magnitudes.
    // Signs stay where the products leave them.
    function automatic fraction_t reduce_fraction(kind_t op,
            logic signed [OPERAND_WIDTH-1:0] an, logic signed [OPERAND_WIDTH-1:0] ad,
            logic signed [OPERAND_WIDTH-1:0] bn, logic signed [OPERAND_WIDTH-1:0] bd);
        fraction_t r;
        longint num, den, x, y, t;
        case (op)
            KIND_ADD: begin num = an * longint'(bd) + bn * longint'(ad);
                            den = ad * longint'(bd); end
            KIND_SUB: begin num = an * longint'(bd) - bn * longint'(ad);
                            den = ad * longint'(bd); end
            KIND_MUL: begin num = an * longint'(bn); den = ad * longint'(bd); end
            default:  begin num = an * longint'(bd); den = ad * longint'(bn); end
        endcase
        if (den == 0) begin
            r.num = 0; r.den = 0; r.err = 1'b1;
        end else if (num == 0) begin
            r.num = 0; r.den = 1; r.err = 1'b0;
        end else begin
            x = (num < 0) ? -num : num;
            y = (den < 0) ? -den : den;
            while (y != 0) begin
                t = x % y;
                x = y;
                y = t;
            end
            r.num = clamp_to_field(num / x);
            r.den = clamp_to_field(den / x);
            r.err = 1'b0;
        end
        return r;
    endfunction

    initial begin
        errors = 0;
        pending = 0;
    end

    always @(posedge clk) begin
        fraction_t want;
        if (rst_n) begin
            if (in_ch.valid && in_ch.ready)
                reduced_q.push_back(reduce_fraction(kind_t'(in_ch.kind), in_ch.a_num,
                    in_ch.a_den, in_ch.b_num, in_ch.b_den));
            if (out_ch.valid && out_ch.ready) begin
                if (reduced_q.size() == 0) begin
                    $error("result %0d/%0d arrived with nothing expected",
                        out_ch.res_num, out_ch.res_den);
                    errors++;
                end else begin
                    want = reduced_q.pop_front();
                    if (out_ch.res_num !== want.num) begin
                        $error("res_num: expected %0d, got %0d", want.num, out_ch.res_num);
                        errors++;
                    end
                    if (out_ch.res_den !== want.den) begin
                        $error("res_den: expected %0d, got %0d", want.den, out_ch.res_den);
                        errors++;
                    end
                    if (out_ch.error !== want.err) begin
                        $error("error: expected %0b, got %0b", want.err, out_ch.error);
                        errors++;
                    end
                end
            end
            pending <= reduced_q.size();
        end
    end

endmodule

// ----- verif/fraction_arithmetic_reduce_unit_tb.sv -----
module fraction_arithmetic_reduce_unit_tb;
    import frac_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int OW = 16;
    localparam int RANDOM_ITEMS = 530;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   errors;
    int   pending;
    logic in_fire = 1'b0;
    int   sent_cnt = 0;
    logic hold_req = 1'b0;

    frac_in_if #(.OPERAND_WIDTH(OW)) in_ch ();
    frac_out_if out_ch ();

    fraction_arithmetic_reduce_unit #(.OPERAND_WIDTH(OW)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (in_ch.sink),
        .out   (out_ch.source)
    );

    fraction_arithmetic_reduce_checker #(.OPERAND_WIDTH(OW)) checker_i (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .errors  (errors),
        .pending (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Record each accepted input transaction so that the driver, which works on
    // the falling edge, sees a settled value.
    always @(posedge clk) in_fire <= in_ch.valid && in_ch.ready;

    // The no-idle stretch covers a run of items in the middle of the test.
    function automatic bit in_quiet_stretch();
        return sent_cnt >= 200 && sent_cnt < 300;
    endfunction

    // Receiver side: random stalls, one long hold-off when requested.
    initial begin
        int hold_left;
        bit hold_used;
        hold_left = 0;
        hold_used = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req && !hold_used) begin
                hold_used = 1;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready = 1'b0;
            end else if (in_quiet_stretch())
                out_ch.ready = 1'b1;
            else
                out_ch.ready = ($urandom_range(99) >= 37);
        end
    end

    // Mostly nonzero operands of random bit length and sign, a few zeros.
    function automatic shortint random_operand();
        int bits;
        int mag;
        if ($urandom_range(99) < 4) return 0;
        bits = $urandom_range(15, 1);
        mag = $urandom_range((1 << bits) - 1, 1);
        return $urandom_range(1) ? -mag : mag;
    endfunction

    task automatic send_fraction(kind_t op, shortint an, shortint ad,
                                 shortint bn, shortint bd);
        int gap;
        if (!in_quiet_stretch() && $urandom_range(99) < 37) begin
            in_ch.valid = 1'b0;
            gap = $urandom_range(4, 1);
            repeat (gap) @(negedge clk);
        end
        in_ch.kind  = op;
        in_ch.a_num = an;
        in_ch.a_den = ad;
        in_ch.b_num = bn;
        in_ch.b_den = bd;
        in_ch.valid = 1'b1;
        do @(negedge clk); while (!in_fire);
        sent_cnt++;
    endtask

    task automatic wait_drained();
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    initial begin
        kind_t   op;
        shortint an, ad, bn, bd;
        in_ch.valid = 1'b0;
        in_ch.kind  = KIND_ADD;
        in_ch.a_num = 0;
        in_ch.a_den = 0;
        in_ch.b_num = 0;
        in_ch.b_den = 0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part: each operation, the zero denominator and zero numerator
        // cases, 0/0, signs left where the products put them, and operand extremes.
        send_fraction(KIND_ADD, 1, 2, 1, 3);
        send_fraction(KIND_SUB, 1, 2, 1, 3);
        send_fraction(KIND_MUL, 2, 3, 9, 4);
        send_fraction(KIND_DIV, 2, 3, 4, 9);
        send_fraction(KIND_ADD, 3, 0, 1, 2);
        send_fraction(KIND_DIV, 5, 7, 0, 3);
        send_fraction(KIND_MUL, 0, 0, 1, 1);
        send_fraction(KIND_MUL, 0, -5, 3, 7);
        send_fraction(KIND_SUB, 4, 6, 2, 3);
        send_fraction(KIND_MUL, 1, -2, 1, 3);
        send_fraction(KIND_DIV, -1, 2, 1, -3);
        send_fraction(KIND_ADD, 32767, 32767, -32767, 32767);
        send_fraction(KIND_MUL, 32767, -32767, -32767, 32767);
        send_fraction(KIND_DIV, -32767, 32767, 32767, -32767);
        send_fraction(KIND_ADD, 32767, 1, 32767, 1);
        send_fraction(KIND_SUB, -32767, -1, 32767, 1);
        send_fraction(KIND_MUL, -32767, 32767, 1, 1);
        send_fraction(KIND_DIV, -1, -1, -1, -1);
        send_fraction(KIND_ADD, -21846, 21845, 21845, -21846);
        send_fraction(KIND_SUB, 0, 32767, 0, -32767);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            op = kind_t'($urandom_range(3));
            an = random_operand();
            ad = random_operand();
            bn = random_operand();
            bd = random_operand();
            // Ask the receiver to hold off while items keep coming, so the block
            // backs up and stalls its input.
            if (i == 100) hold_req = 1'b1;
            // Later the sender stops until every outstanding result has come back.
            if (i == 380) wait_drained();
            send_fraction(op, an, ad, bn, bd);
        end

        wait_drained();
        repeat (200) @(negedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
